// ===== rtl/core/esfc_pkg.sv =====
// Package with the shared types, constants and status codes of the short-frame checker.
`timescale 1ns / 1ps

package esfc_pkg;

    // Frame byte counter size; the counter saturates at MAX_FRAME_BYTES - 1.
    localparam int MAX_FRAME_BYTES = 2048;
    localparam int IDX_W = $clog2(MAX_FRAME_BYTES);
    // Compare width that holds both the counter and the payload end (at most 146).
    localparam int CMP_W = ((IDX_W > 8) ? IDX_W : 8) + 1;

    // Byte positions of the header fields.
    localparam logic [IDX_W-1:0] IDX_TYPE_HI = IDX_W'(12);
    localparam logic [IDX_W-1:0] IDX_TYPE_LO = IDX_W'(13);
    localparam logic [IDX_W-1:0] IDX_MARKER  = IDX_W'(14);
    localparam logic [IDX_W-1:0] IDX_LEN     = IDX_W'(15);
    localparam logic [IDX_W-1:0] IDX_SEQ     = IDX_W'(16);
    localparam logic [IDX_W-1:0] IDX_KIND    = IDX_W'(17);
    localparam logic [IDX_W-1:0] IDX_CSUM    = IDX_W'(18);
    localparam logic [IDX_W-1:0] IDX_PAYLOAD = IDX_W'(19);
    localparam logic [IDX_W-1:0] IDX_LIMIT   = IDX_W'(MAX_FRAME_BYTES - 1);

    // Verdict status codes.
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_SHORT  = 3'd1;
    localparam logic [2:0] ST_ETYPE  = 3'd2;
    localparam logic [2:0] ST_MARKER = 3'd3;
    localparam logic [2:0] ST_CSUM   = 3'd4;
    localparam logic [2:0] ST_TRUNC  = 3'd5;

    // Result kinds.
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // Configuration register indexes and reset values.
    localparam logic REG_ETYPE        = 1'b0;
    localparam logic REG_START_MARKER = 1'b1;
    localparam logic [15:0] ETYPE_RST        = 16'd34997;
    localparam logic [7:0]  START_MARKER_RST = 8'd126;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_end;
    } t_in_item;

    typedef struct packed {
        logic       result_kind;
        logic [7:0] payload_byte;
        logic [2:0] status;
        logic [6:0] data_length;
        logic [4:0] sequence_res;
        logic [3:0] msg_type;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic [15:0] etype;
        logic [7:0]  start_marker;
    } t_cfg;

    // Up to two result items produced by one input byte, first item first.
    typedef struct packed {
        logic [1:0] count;
        t_out_item  item0;
        t_out_item  item1;
    } t_push;

endpackage

// ===== rtl/core/ethernet_short_frame_checker.sv =====
// A result item enters the result queue at the input transfer of its byte.
// Throughput: one byte per cycle; a byte that ends the payload and the frame yields
// two items, which the four-entry result queue drains at one item per cycle while
// the output is ready. Input ready drops only while the result queue holds more
// than two items. Reset (synchronous, active low) clears the frame state and the
// queue, and sets the registers to EtherType 34997 and start marker 126.
`timescale 1ns / 1ps

module ethernet_short_frame_checker
    import esfc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item
);

    t_cfg  w_cfg;
    t_push w_push;
    logic  w_accept;

    assign w_accept = i_in_valid && o_in_ready;

    // Configuration registers.
    esfc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Byte parser.
    esfc_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_accept (w_accept),
        .i_item   (i_in_item),
        .o_push   (w_push)
    );

    // Result queue.
    esfc_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_room  (o_in_ready),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_item)
    );

endmodule

// ===== rtl/core/esfc_cfg_regs.sv =====
// APB-style configuration registers of the short-frame checker.
`timescale 1ns / 1ps

module esfc_cfg_regs
    import esfc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    logic [15:0] r_etype;
    logic [7:0]  r_start_marker;
    logic        w_write;

    assign pready  = 1'b1;
    assign w_write = psel && penable && pwrite;

    // Register writes at the access phase of a write transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_etype        <= ETYPE_RST;
            r_start_marker <= START_MARKER_RST;
        end else if (w_write) begin
            unique case (paddr[2])
                REG_ETYPE:        r_etype        <= pwdata[15:0];
                REG_START_MARKER: r_start_marker <= pwdata[7:0];
                default:          r_etype        <= r_etype;
            endcase
        end
    end

    // Read data mux.
    always_comb begin
        unique case (paddr[2])
            REG_ETYPE:        prdata = {16'd0, r_etype};
            REG_START_MARKER: prdata = {24'd0, r_start_marker};
            default:          prdata = 32'd0;
        endcase
    end

    assign o_cfg.etype        = r_etype;
    assign o_cfg.start_marker = r_start_marker;

endmodule

// ===== rtl/core/esfc_parser.sv =====
// Frame parser: header extraction, checksum accumulation, payload forwarding and verdict generation.
`timescale 1ns / 1ps

module esfc_parser
    import esfc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_accept,
    input  t_in_item i_item,
    output t_push    o_push
);

    logic [IDX_W-1:0] r_byte_index, n_byte_index;
    logic [15:0]      r_type_shift, n_type_shift;
    logic [2:0]       r_error_code, n_error_code;
    logic [6:0]       r_length_reg, n_length_reg;
    logic [4:0]       r_sequence_reg, n_sequence_reg;
    logic [3:0]       r_kind_reg, n_kind_reg;
    logic [7:0]       r_received_sum, n_received_sum;
    logic [7:0]       r_running_sum, n_running_sum;

    logic [7:0]       w_b;
    logic             w_in_payload;
    logic             w_fwd;
    logic [2:0]       w_status;
    t_out_item        w_pay_item;
    t_out_item        w_ver_item;

    assign w_b = i_item.data_byte;

    // Payload window: from byte 19 up to 19 plus the declared length.
    assign w_in_payload = (r_byte_index >= IDX_PAYLOAD) &&
        (CMP_W'(r_byte_index) < (CMP_W'(IDX_PAYLOAD) + CMP_W'(r_length_reg)));

    // Field extraction and running sum for the current byte.
    always_comb begin
        n_type_shift   = r_type_shift;
        n_error_code   = r_error_code;
        n_length_reg   = r_length_reg;
        n_sequence_reg = r_sequence_reg;
        n_kind_reg     = r_kind_reg;
        n_received_sum = r_received_sum;
        n_running_sum  = r_running_sum;
        w_fwd          = 1'b0;
        priority if (r_byte_index == IDX_TYPE_HI || r_byte_index == IDX_TYPE_LO) begin
            n_type_shift = {r_type_shift[7:0], w_b};
            if (r_byte_index == IDX_TYPE_LO && n_type_shift != i_cfg.etype &&
                r_error_code == ST_OK) begin
                n_error_code = ST_ETYPE;
            end
        end else if (r_byte_index == IDX_MARKER) begin
            if (w_b != i_cfg.start_marker && r_error_code == ST_OK) begin
                n_error_code = ST_MARKER;
            end
        end else if (r_byte_index == IDX_LEN) begin
            n_length_reg  = w_b[6:0];
            n_running_sum = r_running_sum + w_b;
        end else if (r_byte_index == IDX_SEQ) begin
            n_sequence_reg = w_b[4:0];
            n_running_sum  = r_running_sum + w_b;
        end else if (r_byte_index == IDX_KIND) begin
            n_kind_reg    = w_b[3:0];
            n_running_sum = r_running_sum + w_b;
        end else if (r_byte_index == IDX_CSUM) begin
            n_received_sum = w_b;
        end else if (w_in_payload) begin
            n_running_sum = r_running_sum + w_b;
            w_fwd         = (r_error_code == ST_OK);
        end
        n_byte_index = (r_byte_index < IDX_LIMIT) ? r_byte_index + 1'b1 : r_byte_index;
    end

    // Verdict status, judged on the count after this byte.
    always_comb begin
        priority if (n_byte_index < IDX_PAYLOAD) begin
            w_status = ST_SHORT;
        end else if (n_error_code != ST_OK) begin
            w_status = n_error_code;
        end else if (CMP_W'(n_byte_index) < (CMP_W'(IDX_PAYLOAD) + CMP_W'(n_length_reg))) begin
            w_status = ST_TRUNC;
        end else if (n_running_sum != n_received_sum) begin
            w_status = ST_CSUM;
        end else begin
            w_status = ST_OK;
        end
    end

    // Result items built from the updated header fields.
    always_comb begin
        w_pay_item.result_kind  = KIND_PAYLOAD;
        w_pay_item.payload_byte = w_b;
        w_pay_item.status       = ST_OK;
        w_pay_item.data_length  = n_length_reg;
        w_pay_item.sequence_res = n_sequence_reg;
        w_pay_item.msg_type     = n_kind_reg;
        w_pay_item.last         = 1'b0;

        w_ver_item.result_kind  = KIND_VERDICT;
        w_ver_item.payload_byte = 8'd0;
        w_ver_item.status       = w_status;
        w_ver_item.data_length  = n_length_reg;
        w_ver_item.sequence_res = n_sequence_reg;
        w_ver_item.msg_type     = n_kind_reg;
        w_ver_item.last         = 1'b1;

        o_push.item0 = w_fwd ? w_pay_item : w_ver_item;
        o_push.item1 = w_ver_item;
        if (!i_accept) begin
            o_push.count = 2'd0;
        end else begin
            o_push.count = {1'b0, w_fwd} + {1'b0, i_item.frame_end};
        end
    end

    // Frame state; every verdict clears it for the next frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_item.frame_end)) begin
            r_byte_index   <= '0;
            r_type_shift   <= '0;
            r_error_code   <= ST_OK;
            r_length_reg   <= '0;
            r_sequence_reg <= '0;
            r_kind_reg     <= '0;
            r_received_sum <= '0;
            r_running_sum  <= '0;
        end else if (i_accept) begin
            r_byte_index   <= n_byte_index;
            r_type_shift   <= n_type_shift;
            r_error_code   <= n_error_code;
            r_length_reg   <= n_length_reg;
            r_sequence_reg <= n_sequence_reg;
            r_kind_reg     <= n_kind_reg;
            r_received_sum <= n_received_sum;
            r_running_sum  <= n_running_sum;
        end
    end

endmodule

// ===== rtl/core/esfc_out_fifo.sv =====
// Four-entry result queue that takes up to two items a cycle and hands out one while the reader is ready.
`timescale 1ns / 1ps

module esfc_out_fifo
    import esfc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_push     i_push,
    output logic      o_room,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);

    t_out_item  r_mem [4];
    logic [1:0] r_wr_ptr, n_wr_ptr;
    logic [1:0] r_rd_ptr, n_rd_ptr;
    logic [2:0] r_count, n_count;
    logic       w_pop;

    // Room for two items keeps the input side free of the output handshake.
    assign o_room  = (r_count <= 3'd2);
    assign o_valid = (r_count != 3'd0);
    assign o_item  = r_mem[r_rd_ptr];
    assign w_pop   = o_valid && i_ready;

    // Pointer and fill count update.
    always_comb begin
        n_wr_ptr = r_wr_ptr + i_push.count;
        n_rd_ptr = r_rd_ptr + {1'b0, w_pop};
        n_count  = r_count + {1'b0, i_push.count} - {2'b00, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry writes: the first item at the write pointer, the second after it.
    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.item0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_wr_ptr + 2'd1] <= i_push.item1;
        end
    end

endmodule

// ===== verif/ethernet_short_frame_checker_test.sv =====
// Self-checking testbench for the Ethernet short-frame checker: directed and random frames.
`timescale 1ns / 1ps

module ethernet_short_frame_checker_test;
    import esfc_pkg::*;

    // Run length and timing.
    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int unsigned RANDOM_BYTES = 720;
    localparam int unsigned PHASES       = 4;
    localparam int unsigned DRAIN_CYCLES = 8;

    // Register addresses on the configuration port.
    localparam logic [2:0] ADDR_ETYPE        = {REG_ETYPE, 2'b00};
    localparam logic [2:0] ADDR_START_MARKER = {REG_START_MARKER, 2'b00};

    // Table markers: the verdict comes from the predictor, the frame is header plus payload, or the filler is random.
    localparam int PREDICTED = -1;
    localparam int FULL      = -1;
    localparam int RANDOM    = -1;

    // Header values that match the registers after reset.
    localparam int ET = int'(ETYPE_RST);
    localparam int MK = int'(START_MARKER_RST);

    // One frame to send: header bytes, checksum damage, total size, filler and verdict.
    typedef struct packed {
        int etype;
        int marker;
        int lenb;
        int seqb;
        int typeb;
        int csum_xor;
        int nbytes;
        int fill;
        int status;
    } frame_row_t;

    localparam int DIRECTED_ROWS = 20;

    frame_row_t directed_rows [DIRECTED_ROWS] = '{
        // Too short: one byte, before the length byte, wrong marker, wrong ethertype.
        '{ET, MK, 5, 1, 2, 0, 1, RANDOM, int'(ST_SHORT)},
        '{ET, MK, 5, 1, 2, 0, 15, RANDOM, int'(ST_SHORT)},
        '{ET, 8'h00, 5, 1, 2, 0, 16, RANDOM, int'(ST_SHORT)},
        '{16'h0000, MK, 8'h7F, 8'h1F, 8'h0F, 0, 18, 8'h00, int'(ST_SHORT)},
        // Good frames: empty payload, one byte, longest payload of all ones, length byte with its top bit set.
        '{ET, MK, 0, 0, 0, 0, FULL, 8'h00, int'(ST_OK)},
        '{ET, MK, 1, 3, 4, 0, FULL, RANDOM, PREDICTED},
        '{ET, MK, 8'h7F, 8'hFF, 8'hFF, 0, FULL, 8'hFF, int'(ST_OK)},
        '{ET, MK, 8'h83, 8'hE0, 8'hF0, 0, FULL, RANDOM, PREDICTED},
        // Header errors suppress the payload.
        '{16'h88B4, MK, 4, 7, 9, 0, FULL, RANDOM, int'(ST_ETYPE)},
        '{16'h08B5, MK, 4, 7, 9, 0, FULL, RANDOM, int'(ST_ETYPE)},
        '{ET, 8'h7F, 4, 7, 9, 0, FULL, RANDOM, int'(ST_MARKER)},
        '{16'hFFFF, 8'h00, 4, 7, 9, 0, FULL, RANDOM, int'(ST_ETYPE)},
        // Checksum errors in the low and high bit.
        '{ET, MK, 6, 2, 3, 8'h01, FULL, RANDOM, int'(ST_CSUM)},
        '{ET, MK, 6, 2, 3, 8'h80, FULL, RANDOM, int'(ST_CSUM)},
        // Truncation, its priority over the checksum and below a header error.
        '{ET, MK, 10, 1, 1, 0, 25, RANDOM, int'(ST_TRUNC)},
        '{ET, MK, 10, 1, 1, 0, 19, RANDOM, int'(ST_TRUNC)},
        '{ET, MK, 10, 1, 1, 8'h55, 22, RANDOM, int'(ST_TRUNC)},
        '{16'h1234, MK, 10, 1, 1, 0, 22, RANDOM, int'(ST_ETYPE)},
        // Trailing padding, short and long.
        '{ET, MK, 3, 5, 6, 0, 30, RANDOM, int'(ST_OK)},
        '{ET, MK, 2, 5, 6, 0, 60, RANDOM, PREDICTED}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_item    i_in_item;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_item   o_out_item;

    // Predictor state of the frame being received and its configuration copy.
    int unsigned frame_pos    = 0;
    logic [15:0] etype_shift  = '0;
    logic [2:0]  hdr_error    = ST_OK;
    logic [6:0]  len_field    = '0;
    logic [4:0]  seq_field    = '0;
    logic [3:0]  type_field   = '0;
    logic [7:0]  csum_field   = '0;
    logic [7:0]  sum_acc      = '0;
    logic [15:0] cfg_etype    = ETYPE_RST;
    logic [7:0]  cfg_marker   = START_MARKER_RST;

    // Results still owed by the block, oldest first.
    t_out_item   pending_results [$];
    logic [7:0]  frame_bytes [$];

    int unsigned err_count    = 0;
    int unsigned cycle_count  = 0;
    int unsigned bytes_sent   = 0;
    int unsigned frames_sent  = 0;
    int unsigned settings     = 1;
    int unsigned payload_seen = 0;
    int unsigned verdict_seen = 0;
    int unsigned status_seen [8];
    int unsigned ready_hold   = 0;

    ethernet_short_frame_checker i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            err_count++;
        end
    endtask

    // Advance the frame model by one byte and queue the results it causes.
    task automatic predict_byte(input logic [7:0] b, input logic fe);
        t_out_item   item;
        logic [2:0]  verdict;
        int unsigned count;
        if (frame_pos == IDX_TYPE_HI || frame_pos == IDX_TYPE_LO) begin
            etype_shift = {etype_shift[7:0], b};
            if (frame_pos == IDX_TYPE_LO && etype_shift != cfg_etype && hdr_error == ST_OK) begin
                hdr_error = ST_ETYPE;
            end
        end else if (frame_pos == IDX_MARKER) begin
            if (b != cfg_marker && hdr_error == ST_OK) begin
                hdr_error = ST_MARKER;
            end
        end else if (frame_pos == IDX_LEN) begin
            len_field = b[6:0];
            sum_acc += b;
        end else if (frame_pos == IDX_SEQ) begin
            seq_field = b[4:0];
            sum_acc += b;
        end else if (frame_pos == IDX_KIND) begin
            type_field = b[3:0];
            sum_acc += b;
        end else if (frame_pos == IDX_CSUM) begin
            csum_field = b;
        end else if (frame_pos >= IDX_PAYLOAD && frame_pos < IDX_PAYLOAD + len_field) begin
            sum_acc += b;
            // Payload is forwarded only while the header is clean.
            if (hdr_error == ST_OK) begin
                item = '{result_kind: KIND_PAYLOAD, payload_byte: b, status: ST_OK,
                         data_length: len_field, sequence_res: seq_field,
                         msg_type: type_field, last: 1'b0};
                pending_results.push_back(item);
            end
        end

        if (frame_pos < IDX_LIMIT) begin
            frame_pos++;
        end

        // Verdict in priority order, then a fresh frame.
        if (fe) begin
            count = frame_pos;
            if (count < IDX_PAYLOAD) begin
                verdict = ST_SHORT;
            end else if (hdr_error != ST_OK) begin
                verdict = hdr_error;
            end else if (count < IDX_PAYLOAD + len_field) begin
                verdict = ST_TRUNC;
            end else if (sum_acc != csum_field) begin
                verdict = ST_CSUM;
            end else begin
                verdict = ST_OK;
            end
            if (count < IDX_LEN + 1) begin
                len_field = '0;
            end
            item = '{result_kind: KIND_VERDICT, payload_byte: 8'h00, status: verdict,
                     data_length: len_field, sequence_res: seq_field,
                     msg_type: type_field, last: 1'b1};
            pending_results.push_back(item);
            frame_pos   = 0;
            etype_shift = '0;
            hdr_error   = ST_OK;
            len_field   = '0;
            seq_field   = '0;
            type_field  = '0;
            csum_field  = '0;
            sum_acc     = '0;
        end
    endtask

    // Lay out the bytes of one frame, with the checksum over what is actually sent.
    task automatic build_frame(input frame_row_t row);
        int         len;
        int         total;
        logic [7:0] sum;
        logic [7:0] filler;
        frame_bytes.delete();
        len   = row.lenb & 'h7F;
        total = (row.nbytes == FULL) ? int'(IDX_PAYLOAD) + len : row.nbytes;
        sum   = 8'(row.lenb + row.seqb + row.typeb);
        for (int i = 0; i < total; i++) begin
            filler = (row.fill == RANDOM) ? 8'($urandom) : 8'(row.fill);
            case (i)
                int'(IDX_TYPE_HI): frame_bytes.push_back(8'(row.etype >> 8));
                int'(IDX_TYPE_LO): frame_bytes.push_back(8'(row.etype));
                int'(IDX_MARKER):  frame_bytes.push_back(8'(row.marker));
                int'(IDX_LEN):     frame_bytes.push_back(8'(row.lenb));
                int'(IDX_SEQ):     frame_bytes.push_back(8'(row.seqb));
                int'(IDX_KIND):    frame_bytes.push_back(8'(row.typeb));
                int'(IDX_CSUM):    frame_bytes.push_back(8'h00);
                default: begin
                    if (i >= int'(IDX_PAYLOAD) && i < int'(IDX_PAYLOAD) + len) begin
                        sum += filler;
                    end
                    frame_bytes.push_back(filler);
                end
            endcase
        end
        if (total > int'(IDX_CSUM)) begin
            frame_bytes[IDX_CSUM] = sum ^ 8'(row.csum_xor);
        end
    endtask

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 75) begin
            return 0;
        end
        if (r < 95) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Send the built frame byte by byte; a typed verdict status replaces the predicted one.
    task automatic send_frame(input bit steady, input int verdict_status);
        t_in_item  item;
        t_out_item verdict;
        int unsigned gap;
        for (int i = 0; i < frame_bytes.size(); i++) begin
            item.data_byte = frame_bytes[i];
            item.frame_end = (i == frame_bytes.size() - 1);
            i_in_valid <= 1'b1;
            i_in_item  <= item;
            predict_byte(item.data_byte, item.frame_end);
            if (item.frame_end && verdict_status != PREDICTED) begin
                verdict = pending_results.pop_back();
                verdict.status = 3'(verdict_status);
                pending_results.push_back(verdict);
            end
            do @(posedge i_clk); while (!o_in_ready);
            bytes_sent++;
            gap = steady ? 0 : pick_gap();
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        frames_sent++;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input logic [2:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Reprogram both registers once the block has gone quiet, and read them back.
    task automatic set_config(input logic [15:0] etype, input logic [7:0] marker);
        logic [31:0] rd;
        i_in_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        apb_access(1'b1, ADDR_ETYPE, {16'h0000, etype}, rd);
        apb_access(1'b1, ADDR_START_MARKER, {24'h000000, marker}, rd);
        apb_access(1'b0, ADDR_ETYPE, '0, rd);
        check_field("etype readback", etype, rd[15:0]);
        apb_access(1'b0, ADDR_START_MARKER, '0, rd);
        check_field("start_marker readback", marker, rd[7:0]);
        cfg_etype  = etype;
        cfg_marker = marker;
        settings++;
    endtask

    // Mostly well-formed frames with random content, the rest damaged or noise.
    function automatic frame_row_t random_row();
        frame_row_t row;
        int         pick;
        int         len;
        pick = $urandom_range(0, 99);
        len  = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 16) : $urandom_range(17, 127);
        row.etype    = cfg_etype;
        row.marker   = cfg_marker;
        row.lenb     = len | ($urandom_range(0, 1) << 7);
        row.seqb     = $urandom_range(0, 255);
        row.typeb    = $urandom_range(0, 255);
        row.csum_xor = 0;
        row.fill     = RANDOM;
        row.status   = PREDICTED;
        row.nbytes   = int'(IDX_PAYLOAD) + len
                     + (($urandom_range(0, 9) < 3) ? $urandom_range(1, 8) : 0);
        if (pick < 70) begin
            row.status = PREDICTED;
        end else if (pick < 80) begin
            row.csum_xor = $urandom_range(1, 255);
        end else if (pick < 87) begin
            if ($urandom_range(0, 1) == 1) begin
                row.etype = cfg_etype ^ $urandom_range(1, 65535);
            end else begin
                row.marker = cfg_marker ^ $urandom_range(1, 255);
            end
        end else if (pick < 94) begin
            if (len == 0) begin
                len      = $urandom_range(1, 16);
                row.lenb = len;
            end
            row.nbytes = int'(IDX_PAYLOAD) + $urandom_range(0, len - 1);
        end else begin
            row.nbytes = $urandom_range(1, 40);
            if ($urandom_range(0, 1) == 1) begin
                row.etype  = $urandom_range(0, 65535);
                row.marker = $urandom_range(0, 255);
            end
        end
        return row;
    endfunction

    // Result side: random stalls, with long open stretches now and then.
    always @(posedge i_clk) begin : ready_gen
        int unsigned pick;
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                i_out_ready <= 1'b1;
                ready_hold  <= $urandom_range(50, 150);
            end else if (pick < 55) begin
                i_out_ready <= 1'b1;
                ready_hold  <= $urandom_range(0, 20);
            end else if (pick < 90) begin
                i_out_ready <= 1'b0;
                ready_hold  <= $urandom_range(0, 2);
            end else begin
                i_out_ready <= 1'b0;
                ready_hold  <= $urandom_range(8, 40);
            end
        end
    end

    // Compare every result transfer with the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing expected, expected none, actual %h",
                         $time, o_out_item);
                err_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("result_kind", want.result_kind, o_out_item.result_kind);
                check_field("payload_byte", want.payload_byte, o_out_item.payload_byte);
                check_field("status", want.status, o_out_item.status);
                check_field("data_length", want.data_length, o_out_item.data_length);
                check_field("sequence_res", want.sequence_res, o_out_item.sequence_res);
                check_field("msg_type", want.msg_type, o_out_item.msg_type);
                check_field("last", want.last, o_out_item.last);
                if (o_out_item.result_kind == KIND_VERDICT) begin
                    verdict_seen++;
                    status_seen[o_out_item.status]++;
                end else begin
                    payload_seen++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Run stopped at the cycle limit with %0d results outstanding",
                     pending_results.size());
            $display("FAIL ethernet_short_frame_checker");
            $finish;
        end
    end

    // Main sequence: reset, directed frames, then random phases under several settings.
    initial begin : stimulus
        logic [31:0] rd;
        int unsigned goal;
        i_rst_n     <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        i_in_valid  <= 1'b0;
        i_in_item   <= '0;
        i_out_ready <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Registers come out of reset with their documented values.
        apb_access(1'b0, ADDR_ETYPE, '0, rd);
        check_field("etype after reset", ETYPE_RST, rd[15:0]);
        apb_access(1'b0, ADDR_START_MARKER, '0, rd);
        check_field("start_marker after reset", START_MARKER_RST, rd[7:0]);

        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            build_frame(directed_rows[r]);
            send_frame(r % 2 == 0, directed_rows[r].status);
        end

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: set_config(16'h0000, 8'h00);
                1: set_config(16'hFFFF, 8'hFF);
                default: set_config(16'($urandom), 8'($urandom));
            endcase
            goal = bytes_sent + RANDOM_BYTES / PHASES;
            while (bytes_sent < goal) begin
                build_frame(random_row());
                send_frame($urandom_range(0, 3) == 0, PREDICTED);
                // Now and then hold off until the block has emptied.
                if ($urandom_range(0, 29) == 0) begin
                    i_in_valid <= 1'b0;
                    wait_drained();
                end
            end
        end

        i_in_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d frames (%0d bytes) under %0d register settings.",
                 frames_sent, bytes_sent, settings);
        $display("Checked %0d payload bytes and %0d verdicts: ok %0d, short %0d, %0d %0d %0d %0d.",
                 payload_seen, verdict_seen, status_seen[ST_OK], status_seen[ST_SHORT],
                 status_seen[ST_ETYPE], status_seen[ST_MARKER], status_seen[ST_CSUM],
                 status_seen[ST_TRUNC]);
        if (err_count == 0) begin
            $display("PASS ethernet_short_frame_checker");
        end else begin
            $display("FAIL ethernet_short_frame_checker");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/esfc_pkg.sv
rtl/core/esfc_cfg_regs.sv
rtl/core/esfc_parser.sv
rtl/core/esfc_out_fifo.sv
rtl/core/ethernet_short_frame_checker.sv
verif/ethernet_short_frame_checker_test.sv
